>>> rtl/fdqb_pkg.sv
// ---------------------------------------------------------------------------
// Fault debounce qualifier bank package
// Shared sizes, codes and types for the fault debounce qualifier bank.
// ---------------------------------------------------------------------------
package fdqb_pkg;

  // Field widths of one request beat.
  localparam int BANK_W = 1;
  localparam int CARD_W = 1;
  localparam int FIDX_W = 4;

  // Bank geometry and counter size.
  localparam int BANKS           = 2;
  localparam int CARDS           = 2;
  localparam int FAULTS_PER_CARD = 16;
  localparam int COUNT_W         = 16;
  localparam int ENTRIES         = BANKS * CARDS * FAULTS_PER_CARD;
  localparam int ADDR_W          = $clog2(ENTRIES);

  // Configuration port.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CMP_W     = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;

  localparam logic [CFG_W-1:0]   THRESH_RESET = CFG_W'(20);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  // Entry word: {flag, clear counter, set counter}.
  localparam int WORD_W = 2 * COUNT_W + 1;
  localparam int FLAG_BIT = 2 * COUNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_SET_COUNT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_COUNT = CFG_IDX_W'(1);

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_RESET = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } fdqb_state_e;

endpackage

>>> rtl/fdqb_if.sv
// ---------------------------------------------------------------------------
// Fault debounce qualifier bank channels
// Request and response channels with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface fdqb_req_if
  import fdqb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BANK_W-1:0] bank;
  logic [CARD_W-1:0] card;
  logic [FIDX_W-1:0] fault_index;
  logic              opcode;

  modport source (output valid, bank, card, fault_index, opcode, input ready);
  modport sink   (input valid, bank, card, fault_index, opcode, output ready);
endinterface

interface fdqb_rsp_if;
  logic valid;
  logic ready;
  logic fault_flag;

  modport source (output valid, fault_flag, input ready);
  modport sink   (input valid, fault_flag, output ready);
endinterface

>>> rtl/fault_debounce_qualifier_bank.sv
// ---------------------------------------------------------------------------
// Fault debounce qualifier bank
// Debounces fault set and reset requests per entry and returns the flag.
// ---------------------------------------------------------------------------
// A taken request beat registers its fields and the addressed entry; the
// response is loaded into the output reg in the update state, which waits
// while an earlier response is not yet taken. A new request is taken only
// after the read-modify-write of the single-ported entry store (read, then
// update and write), even while an earlier response waits in the output reg.
// Reset: thresholds return to 20 and all entry valid bits clear at once, so
// every entry reads as zero counters and a lowered flag; no clearing pass.
module fault_debounce_qualifier_bank
  import fdqb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  fdqb_req_if.sink             req_i,
  fdqb_rsp_if.source           rsp_o
);

  fdqb_state_e state_q, state_d;

  logic [CFG_W-1:0] set_count_q, clear_count_q;

  logic [WORD_W-1:0] mem_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [WORD_W-1:0]  rdata_q;
  logic               rvalid_q;

  logic [ADDR_W-1:0] addr_d, addr_q;
  logic              in_range_d, in_range_q;
  logic              opcode_q;

  logic out_valid_q;
  logic out_flag_q;

  logic accept;
  logic can_load;
  logic out_load;
  logic mem_we;

  logic [COUNT_W-1:0] rd_set, rd_clr, own, other, inc, new_own, new_other;
  logic               rd_flag, new_flag, hit;
  logic [CFG_W-1:0]   thr;
  logic [WORD_W-1:0]  wdata;

  assign accept   = req_i.valid && req_i.ready;
  assign can_load = !out_valid_q || rsp_o.ready;

  assign in_range_d = (32'(req_i.card) < CARDS) && (32'(req_i.fault_index) < FAULTS_PER_CARD);
  assign addr_d = ADDR_W'((ADDR_W'(req_i.bank) * ADDR_W'(CARDS) + ADDR_W'(req_i.card))
                  * ADDR_W'(FAULTS_PER_CARD) + ADDR_W'(req_i.fault_index));

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_UPDATE;
      ST_UPDATE: if (can_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    req_i.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE:   req_i.ready = 1'b1;
      ST_UPDATE: out_load = can_load;
      default:   req_i.ready = 1'b0;
    endcase
  end

  assign mem_we = out_load && in_range_q;

  // Shared update unit: one increment and one threshold compare per request.
  always_comb begin
    rd_set  = rvalid_q ? rdata_q[COUNT_W-1:0] : '0;
    rd_clr  = rvalid_q ? rdata_q[2*COUNT_W-1:COUNT_W] : '0;
    rd_flag = rvalid_q ? rdata_q[FLAG_BIT] : 1'b0;

    own   = (opcode_q == OP_SET) ? rd_set : rd_clr;
    other = (opcode_q == OP_SET) ? rd_clr : rd_set;
    thr   = (opcode_q == OP_SET) ? set_count_q : clear_count_q;

    inc = own + COUNT_W'(own != COUNT_MAX);
    hit = CMP_W'(inc) >= CMP_W'(thr);

    new_own   = hit ? COUNT_W'(thr) : inc;
    new_other = hit ? '0 : other;
    new_flag  = hit ? (opcode_q == OP_SET) : rd_flag;

    if (opcode_q == OP_SET) begin
      wdata = {new_flag, new_other, new_own};
    end else begin
      wdata = {new_flag, new_own, new_other};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      set_count_q   <= THRESH_RESET;
      clear_count_q <= THRESH_RESET;
      valid_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_SET_COUNT:   set_count_q <= cfg_wdata_i;
          REG_CLEAR_COUNT: clear_count_q <= cfg_wdata_i;
          default:         ;
        endcase
      end
      if (mem_we) valid_q[addr_q] <= 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request fields, read data and output payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q     <= addr_d;
      in_range_q <= in_range_d;
      opcode_q   <= req_i.opcode;
      rdata_q    <= mem_q[addr_d];
      rvalid_q   <= valid_q[addr_d];
    end
    if (mem_we) mem_q[addr_q] <= wdata;
    if (out_load) out_flag_q <= in_range_q ? new_flag : 1'b0;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.fault_flag = out_flag_q;

  a_accept_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_UPDATE)
    else $error("accepted request did not enter the update state");

  a_write_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> rsp_o.valid)
    else $error("entry written without a response beat");

  a_flag_matches_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> rsp_o.fault_flag == $past(wdata[FLAG_BIT]))
    else $error("response flag differs from the stored flag");

  a_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> valid_q[$past(addr_q)])
    else $error("written entry not marked valid");

endmodule
